/* hw/rtl/tiered_weighted_version_picker_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tiered weighted version picker
// Clocked on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIERED_WEIGHTED_VERSION_PICKER_TOP_DEFINES_SVH
`define TIERED_WEIGHTED_VERSION_PICKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TWVP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("twvp: property violated");
`define TWVP_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("twvp: forbidden condition");
`else
`define TWVP_ASSERT(lbl, prop)
`define TWVP_NEVER(lbl, expr)
`endif

`endif

/* hw/rtl/twvp_pkg.sv */
// ----------------------------------------------------------------------------
// twvp_pkg
// Types, codes and helpers for the tiered weighted version picker.
// ----------------------------------------------------------------------------
package twvp_pkg;

	localparam int MAX_VERSIONS_DEF = 16;

	localparam int ID_W     = 32;
	localparam int WGT_W    = 16;
	localparam int TIER_W   = 2;
	localparam int PROV_W   = 16;
	localparam int S_DATA_W = 168;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = ID_W;
	localparam int M_USER_W = 4;
	localparam int SRC_W    = 32;
	localparam int BIT_W    = 5;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_SELECT = 2'd2;

	localparam logic [1:0] TIER_COMPLETE   = 2'd0;
	localparam logic [1:0] TIER_INCOMPLETE = 2'd1;
	localparam logic [1:0] TIER_STOPPED    = 2'd2;
	localparam logic [1:0] TIER_RESERVED   = 2'd3;
	localparam int         NUM_TIERS       = 3;

	localparam logic [2:0] ROUTE_REQUIRED  = 3'd0;
	localparam logic [2:0] ROUTE_PREFERRED = 3'd1;
	localparam logic [2:0] ROUTE_SOLE      = 3'd2;
	localparam logic [2:0] ROUTE_COMPLETE  = 3'd3;
	localparam logic [2:0] ROUTE_NONE      = 3'd6;

	typedef struct packed {
		logic              parts;
		logic [PROV_W-1:0] prov;
		logic [TIER_W-1:0] tier;
		logic [WGT_W-1:0]  weight;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_SHIFT,
		ST_WRITE,
		ST_SUM,
		ST_DECIDE,
		ST_MOD,
		ST_WALK,
		ST_EMIT
	} state_t;

	// weight of an entry within tier t; use_prov picks the fallback weights
	function automatic logic [WGT_W-1:0] tier_w(entry_t e, logic [1:0] t, logic use_prov);
		logic [1:0]       et;
		logic [WGT_W-1:0] w;
		et = (e.tier == TIER_RESERVED) ? TIER_STOPPED : e.tier;
		if (!e.parts || et != t) begin
			w = '0;
		end else if (use_prov) begin
			w = e.prov;
		end else if (t == TIER_STOPPED) begin
			w = WGT_W'(1);
		end else begin
			w = e.weight;
		end
		return w;
	endfunction

endpackage

/* hw/rtl/tiered_weighted_version_picker_top.sv */
// ----------------------------------------------------------------------------
// tiered_weighted_version_picker_top: version table with tiered weighted pick
// Add: locate the slot, shift higher entries up, write (a duplicate id is rewritten in place).
// Select: scan, decide, 32 remainder steps, walk, emit.
// One word at a time: a new word is accepted only in idle, once the last one is through.
// Reset empties the table, entries need no clearing pass.
// ----------------------------------------------------------------------------
`include "tiered_weighted_version_picker_top_defines.svh"

module tiered_weighted_version_picker_top
	import twvp_pkg::*;
#(
	parameter int MAX_VERSIONS = MAX_VERSIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// version_id, weight, tier, provider_count, has_parts, source_id,
	// want_valid, want_version, prefer_valid, prefer_version, zero pad
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// cmd
	input  logic [S_USER_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// chosen_version
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// found, route
	output logic [M_USER_W-1:0] m_axis_tuser
);

	localparam int CNT_W = $clog2(MAX_VERSIONS + 1);
	localparam int IDX_W = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
	localparam int SUM_W = WGT_W + $clog2(MAX_VERSIONS);

	state_t state_q, state_d;

	entry_t mem [MAX_VERSIONS];
	entry_t rd_data_s1;
	logic   rd_vld_s1;
	logic [CNT_W-1:0] rd_idx_s1;

	logic [CNT_W-1:0] count_q, idx_q, idx_m1, pos_q;
	logic             dup_q;

	entry_t           new_q;
	logic [SRC_W-1:0] src_q;
	logic             want_v_q, pref_v_q, want_hit_q, pref_hit_q;
	logic [ID_W-1:0]  want_id_q, pref_id_q, id0_q;

	logic [SUM_W-1:0] wsum_q [NUM_TIERS];
	logic [SUM_W-1:0] psum_q [NUM_TIERS];

	logic [1:0]       sel_tier_q;
	logic             sel_prov_q;
	logic [SUM_W-1:0] sel_sum_q, rem_q, rem_d, key_q;
	logic [SUM_W:0]   rem_sh;
	logic [BIT_W-1:0] bit_q;

	logic [ID_W-1:0]  res_id_q;
	logic             res_found_q;
	logic [2:0]       res_route_q;

	logic                m_vld_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic [M_USER_W-1:0] m_user_q;

	logic             s_accept, issue, scan_done, emit_go, walk_hit, full;
	logic [IDX_W-1:0] rd_addr, mem_wa;
	logic             mem_we;
	entry_t           mem_wd;
	logic [WGT_W-1:0] walk_w;

	logic             dec_to_mod, dec_found, sel_ok, sel_prov;
	logic [ID_W-1:0]  dec_id;
	logic [2:0]       dec_route;
	logic [1:0]       sel_tier;
	logic [SUM_W-1:0] sel_sum;

	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign idx_m1   = idx_q - CNT_W'(1);
	assign full     = (count_q == CNT_W'(MAX_VERSIONS));
	assign walk_w   = tier_w(rd_data_s1, sel_tier_q, sel_prov_q);
	assign rem_sh   = {rem_q, src_q[SRC_W-1]};
	assign rem_d    = (rem_sh >= {1'b0, sel_sum_q}) ? SUM_W'(rem_sh - {1'b0, sel_sum_q})
	                                                : SUM_W'(rem_sh);

	// control outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		issue         = 1'b0;
		rd_addr       = idx_q[IDX_W-1:0];
		mem_we        = 1'b0;
		mem_wa        = rd_idx_s1[IDX_W-1:0];
		mem_wd        = rd_data_s1;
		unique case (state_q)
			ST_FIND, ST_SUM, ST_WALK: begin
				issue = (idx_q < count_q);
			end
			ST_SHIFT: begin
				issue   = (idx_q > pos_q);
				rd_addr = idx_m1[IDX_W-1:0];
				mem_we  = rd_vld_s1;
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				mem_wa = pos_q[IDX_W-1:0];
				mem_wd = new_q;
			end
			default: begin
			end
		endcase
		scan_done = !issue && !rd_vld_s1;
		emit_go   = (state_q == ST_EMIT) && (!m_vld_q || m_axis_tready);
		walk_hit  = (state_q == ST_WALK) && rd_vld_s1 && ({{(SUM_W-WGT_W){1'b0}}, walk_w} > key_q);
	end

	// tier choice and early routes
	always_comb begin
		sel_ok   = 1'b0;
		sel_tier = TIER_COMPLETE;
		sel_prov = 1'b0;
		sel_sum  = '0;
		for (int t = 0; t < NUM_TIERS; t++) begin
			if (!sel_ok && wsum_q[t] != '0) begin
				sel_ok   = 1'b1;
				sel_tier = 2'(t);
				sel_prov = 1'b0;
				sel_sum  = wsum_q[t];
			end else if (!sel_ok && psum_q[t] != '0) begin
				sel_ok   = 1'b1;
				sel_tier = 2'(t);
				sel_prov = 1'b1;
				sel_sum  = psum_q[t];
			end
		end
		dec_to_mod = 1'b0;
		dec_found  = 1'b0;
		dec_id     = '0;
		dec_route  = ROUTE_NONE;
		priority if (count_q == '0) begin
		end else if (want_v_q) begin
			if (want_hit_q) begin
				dec_found = 1'b1;
				dec_id    = want_id_q;
				dec_route = ROUTE_REQUIRED;
			end
		end else if (pref_v_q && pref_hit_q) begin
			dec_found = 1'b1;
			dec_id    = pref_id_q;
			dec_route = ROUTE_PREFERRED;
		end else if (count_q == CNT_W'(1)) begin
			dec_found = 1'b1;
			dec_id    = id0_q;
			dec_route = ROUTE_SOLE;
		end else begin
			dec_to_mod = sel_ok;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					unique case (s_axis_tuser)
						CMD_ADD:    state_d = ST_FIND;
						CMD_SELECT: state_d = ST_SUM;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_FIND: begin
				if (scan_done) begin
					priority if (dup_q) state_d = ST_WRITE;
					else if (full)      state_d = ST_IDLE;
					else                state_d = ST_SHIFT;
				end
			end
			ST_SHIFT:  if (scan_done) state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_IDLE;
			ST_SUM:    if (scan_done) state_d = ST_DECIDE;
			ST_DECIDE: state_d = dec_to_mod ? ST_MOD : ST_EMIT;
			ST_MOD:    if (bit_q == '0) state_d = ST_WALK;
			ST_WALK:   if (walk_hit || scan_done) state_d = ST_EMIT;
			ST_EMIT:   if (emit_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			m_vld_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (s_accept && s_axis_tuser == CMD_CLEAR) begin
				count_q <= '0;
			end else if (state_q == ST_WRITE && !dup_q) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (emit_go) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[rd_addr];
		rd_idx_s1  <= idx_q;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_q <= (state_q == ST_SHIFT) ? idx_m1 : idx_q + CNT_W'(1);
		end
		if (emit_go) begin
			m_data_q <= res_id_q;
			m_user_q <= {res_route_q, res_found_q};
		end
		unique case (state_q)
			ST_IDLE: begin
				idx_q      <= '0;
				pos_q      <= '0;
				dup_q      <= 1'b0;
				want_hit_q <= 1'b0;
				pref_hit_q <= 1'b0;
				for (int t = 0; t < NUM_TIERS; t++) begin
					wsum_q[t] <= '0;
					psum_q[t] <= '0;
				end
				new_q.id     <= s_axis_tdata[31:0];
				new_q.weight <= s_axis_tdata[47:32];
				new_q.tier   <= s_axis_tdata[49:48];
				new_q.prov   <= s_axis_tdata[65:50];
				new_q.parts  <= s_axis_tdata[66];
				src_q        <= s_axis_tdata[98:67];
				want_v_q     <= s_axis_tdata[99];
				want_id_q    <= s_axis_tdata[131:100];
				pref_v_q     <= s_axis_tdata[132];
				pref_id_q    <= s_axis_tdata[164:133];
			end
			ST_FIND: begin
				if (rd_vld_s1) begin
					if (rd_data_s1.id < new_q.id) pos_q <= pos_q + CNT_W'(1);
					if (rd_data_s1.id == new_q.id) dup_q <= 1'b1;
				end
				if (scan_done) idx_q <= count_q;
			end
			ST_SUM: begin
				if (rd_vld_s1) begin
					for (int t = 0; t < NUM_TIERS; t++) begin
						wsum_q[t] <= wsum_q[t] + SUM_W'(tier_w(rd_data_s1, 2'(t), 1'b0));
						psum_q[t] <= psum_q[t] + SUM_W'(tier_w(rd_data_s1, 2'(t), 1'b1));
					end
					if (rd_data_s1.id == want_id_q) want_hit_q <= 1'b1;
					if (rd_data_s1.id == pref_id_q) pref_hit_q <= 1'b1;
					if (rd_idx_s1 == '0) id0_q <= rd_data_s1.id;
				end
			end
			ST_DECIDE: begin
				res_found_q <= dec_found;
				res_id_q    <= dec_id;
				res_route_q <= dec_route;
				sel_tier_q  <= sel_tier;
				sel_prov_q  <= sel_prov;
				sel_sum_q   <= sel_sum;
				rem_q       <= '0;
				bit_q       <= BIT_W'(SRC_W - 1);
			end
			ST_MOD: begin
				rem_q <= rem_d;
				src_q <= src_q << 1;
				bit_q <= bit_q - BIT_W'(1);
				if (bit_q == '0) begin
					key_q <= rem_d;
					idx_q <= '0;
				end
			end
			ST_WALK: begin
				if (walk_hit) begin
					res_found_q <= 1'b1;
					res_id_q    <= rd_data_s1.id;
					res_route_q <= ROUTE_COMPLETE + {1'b0, sel_tier_q};
				end else if (rd_vld_s1) begin
					key_q <= key_q - SUM_W'(walk_w);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	`TWVP_NEVER(a_count_range, count_q > CNT_W'(MAX_VERSIONS))
	`TWVP_ASSERT(a_shift_above_pos, (state_q == ST_SHIFT && rd_vld_s1) |-> (rd_idx_s1 > pos_q))
	`TWVP_ASSERT(a_rem_below_sum, (state_q == ST_MOD) |-> (rem_q < sel_sum_q))
	`TWVP_ASSERT(a_emit_origin, $rose(m_vld_q) |-> $past(state_q == ST_EMIT))
	`TWVP_ASSERT(a_none_is_zero, (m_vld_q && !m_user_q[0]) |-> (m_data_q == '0 && m_user_q[3:1] == ROUTE_NONE))

endmodule
